// ===== hdl/asft_pkg.sv =====
// Shared types and constants for the ADPCM sample FIFO and timing block.
package asft_pkg;

    localparam int FIFO_DEPTH_DEF     = 16;
    localparam int COUNTER_PERIOD_DEF = 512;
    localparam int POP_COUNT          = 4;
    localparam int STROBE_COUNT       = 64;
    localparam int PHASE_BIT          = 2;
    localparam int FILL_W             = 5;
    localparam int BYTE_W             = 8;
    localparam int CTL_RESET_BIT      = 0;
    localparam int CTL_DIV4_BIT       = 4;
    localparam int CTL_DIV2_BIT       = 5;
    localparam int CTL_DIV1_BIT       = 6;

    typedef enum logic [1:0] {
        REQ_TICK = 2'd0,
        REQ_PUSH = 2'd1,
        REQ_CTC  = 2'd2,
        REQ_CTRL = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        DIV_1 = 3'd1,
        DIV_2 = 3'd2,
        DIV_4 = 3'd4
    } t_div;

    typedef struct packed {
        t_req              req_type;
        logic [BYTE_W-1:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic              trigger_two_pulse;
        logic              trigger_three_level;
        logic              sample_strobe;
        logic [BYTE_W-1:0] sample_byte;
        logic              decoder_reset;
        logic [FILL_W-1:0] fifo_fill;
    } t_out_item;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

// ===== hdl/asft_mem.sv =====
// Sample store: one write port, one read port with registered read data.
module asft_mem #(
    parameter int  DEPTH = asft_pkg::FIFO_DEPTH_DEF,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  asft_pkg::t_mem_ctl         i_ctl,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [asft_pkg::BYTE_W-1:0] i_wr_data,
    input  logic [AW-1:0]              i_rd_addr,
    output logic [asft_pkg::BYTE_W-1:0] o_rd_data
);
    import asft_pkg::*;

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/asft_ctrl.sv =====
// Event decode, tick timing, FIFO pointers and the registered result stage.
module asft_ctrl #(
    parameter int  FIFO_DEPTH     = asft_pkg::FIFO_DEPTH_DEF,
    parameter int  COUNTER_PERIOD = asft_pkg::COUNTER_PERIOD_DEF,
    localparam int AW             = $clog2(FIFO_DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  asft_pkg::t_in_item          i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output asft_pkg::t_out_item         o_out_data,
    output asft_pkg::t_mem_ctl          o_mem_ctl,
    output logic [AW-1:0]               o_wr_addr,
    output logic [asft_pkg::BYTE_W-1:0] o_wr_data,
    output logic [AW-1:0]               o_rd_addr,
    input  logic [asft_pkg::BYTE_W-1:0] i_rd_data
);
    import asft_pkg::*;

    localparam int FW = $clog2(FIFO_DEPTH + 1);
    localparam int CW = $clog2(COUNTER_PERIOD);

    logic [FW-1:0] r_fill, n_fill;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_phase, n_phase;
    t_div          r_div, n_div;
    logic          r_trig, n_trig;
    logic          r_rst_lvl, n_rst_lvl;
    logic          r_pushed, n_pushed;
    logic          r_held_ok, n_held_ok;
    logic          r_out_valid, n_out_valid;
    t_out_item     r_out, n_out;

    logic          accept;
    logic [AW-1:0] head_inc;
    logic [CW-1:0] cnt_inc;
    logic [FW-1:0] fill_dec;
    logic [AW-1:0] pop_ofs;
    logic [AW:0]   head_ext;
    logic [AW:0]   ofs_ext;
    logic [AW:0]   rd_ext;
    logic [2:0]    div_mask;
    logic          pulse;
    logic          strobe;
    logic [BYTE_W-1:0] sbyte;
    t_mem_ctl      mem_ctl;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    assign head_inc = (r_head == AW'(FIFO_DEPTH - 1)) ? '0 : r_head + AW'(1);
    assign cnt_inc  = (r_cnt == CW'(COUNTER_PERIOD - 1)) ? '0 : r_cnt + CW'(1);
    assign fill_dec = (r_fill != '0) ? r_fill - FW'(1) : '0;
    assign pop_ofs  = AW'(fill_dec);
    assign head_ext = {1'b0, r_head};
    assign ofs_ext  = {1'b0, pop_ofs};
    assign rd_ext   = (head_ext >= ofs_ext) ? head_ext - ofs_ext
                                            : head_ext + (AW+1)'(FIFO_DEPTH) - ofs_ext;
    assign div_mask = 3'(r_div) - 3'd1;

    always_comb begin
        n_fill    = r_fill;
        n_head    = r_head;
        n_cnt     = r_cnt;
        n_phase   = r_phase;
        n_div     = r_div;
        n_trig    = r_trig;
        n_rst_lvl = r_rst_lvl;
        n_pushed  = r_pushed;
        n_held_ok = r_held_ok;
        mem_ctl   = '0;
        pulse     = 1'b0;
        strobe    = 1'b0;
        sbyte     = '0;
        if (accept) begin
            unique case (i_in_data.req_type)
                REQ_TICK: begin
                    pulse   = (r_cnt[2:0] & div_mask) == 3'd0;
                    n_phase = r_cnt[PHASE_BIT];
                    n_trig  = (r_fill != '0) || r_cnt[PHASE_BIT];
                    if (r_cnt == CW'(POP_COUNT)) begin
                        mem_ctl.rd_en = 1'b1;
                        n_fill        = fill_dec;
                        n_held_ok     = r_pushed;
                    end
                    if ((n_fill != '0) && (r_cnt == CW'(STROBE_COUNT))) begin
                        strobe = 1'b1;
                        sbyte  = r_held_ok ? i_rd_data : '0;
                    end
                    n_cnt = cnt_inc;
                end
                REQ_PUSH: begin
                    mem_ctl.wr_en = 1'b1;
                    n_head        = head_inc;
                    n_fill        = (r_fill == FW'(FIFO_DEPTH)) ? r_fill : r_fill + FW'(1);
                    n_trig        = 1'b1;
                    n_pushed      = 1'b1;
                end
                REQ_CTC: begin
                    if (i_in_data.data_byte != '0) begin
                        n_cnt   = '0;
                        n_phase = 1'b0;
                        n_trig  = r_fill != '0;
                    end
                end
                REQ_CTRL: begin
                    n_rst_lvl = i_in_data.data_byte[CTL_RESET_BIT];
                    if (i_in_data.data_byte[CTL_RESET_BIT]) begin
                        n_fill = '0;
                        n_trig = r_phase;
                    end
                    if (i_in_data.data_byte[CTL_DIV1_BIT]) begin
                        n_div = DIV_1;
                    end else if (i_in_data.data_byte[CTL_DIV2_BIT]) begin
                        n_div = DIV_2;
                    end else if (i_in_data.data_byte[CTL_DIV4_BIT]) begin
                        n_div = DIV_4;
                    end
                end
                default: begin
                    n_fill = r_fill;
                end
            endcase
        end
    end

    always_comb begin
        n_out.trigger_two_pulse   = pulse;
        n_out.trigger_three_level = n_trig;
        n_out.sample_strobe       = strobe;
        n_out.sample_byte         = sbyte;
        n_out.decoder_reset       = n_rst_lvl;
        n_out.fifo_fill           = FILL_W'(n_fill);
        n_out_valid               = accept || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_head      <= '0;
            r_cnt       <= '0;
            r_phase     <= 1'b0;
            r_div       <= DIV_1;
            r_trig      <= 1'b0;
            r_rst_lvl   <= 1'b0;
            r_pushed    <= 1'b0;
            r_held_ok   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_head      <= n_head;
            r_cnt       <= n_cnt;
            r_phase     <= n_phase;
            r_div       <= n_div;
            r_trig      <= n_trig;
            r_rst_lvl   <= n_rst_lvl;
            r_pushed    <= n_pushed;
            r_held_ok   <= n_held_ok;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_mem_ctl   = mem_ctl;
    assign o_wr_addr   = head_inc;
    assign o_wr_data   = i_in_data.data_byte;
    assign o_rd_addr   = AW'(rd_ext);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(FIFO_DEPTH))
        else $error("fill count above depth");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(COUNTER_PERIOD - 1))
        else $error("tick counter out of range");

    a_push_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_in_data.req_type == REQ_PUSH) |=> (r_fill != '0) && r_pushed)
        else $error("push left fifo empty");

    a_strobe_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !strobe |=> (r_out.sample_byte == '0))
        else $error("sample byte without strobe");

    a_mem_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_ctl.wr_en && mem_ctl.rd_en))
        else $error("read and write in one transfer");

endmodule

// ===== hdl/adpcm_sample_fifo_timing.sv =====
// Sample FIFO and tick timing for an ADPCM decoder. One event is taken per clock
// unless input is stalled, and its result appears in the output register on the
// next cycle; the sample store takes one write (byte push) or one read (pop on
// the tick at count four) per event. Input stall rises only while a result waits
// under output stall. No clearing pass after reset.
module adpcm_sample_fifo_timing #(
    parameter int FIFO_DEPTH     = asft_pkg::FIFO_DEPTH_DEF,
    parameter int COUNTER_PERIOD = asft_pkg::COUNTER_PERIOD_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  asft_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output asft_pkg::t_out_item o_out_data
);
    import asft_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);

    t_mem_ctl          mem_ctl;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [BYTE_W-1:0] wr_data;
    logic [BYTE_W-1:0] rd_data;

    asft_ctrl #(
        .FIFO_DEPTH     (FIFO_DEPTH),
        .COUNTER_PERIOD (COUNTER_PERIOD)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .o_mem_ctl   (mem_ctl),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    asft_mem #(
        .DEPTH (FIFO_DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule

// ===== tb/tb_adpcm_sample_fifo_timing.sv =====
// Self-checking testbench for the ADPCM sample FIFO and tick timing block.
`timescale 1ns / 100ps

module tb_adpcm_sample_fifo_timing;
    import asft_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 11;
    localparam int ITEM_TARGET    = 1600;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 80;
    localparam int HOLD_AFTER     = 400;
    localparam int PRINT_LIMIT    = 40;

    typedef struct packed {
        t_in_item  item;
        logic      typed;
        t_out_item want;
    } t_event;

    typedef struct packed {
        t_req      req;
        logic [7:0] data;
        logic [7:0] reps;
        logic      typed;
        t_out_item want;
    } t_dir_row;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      out_stall = 1'b0;
    logic      hold_off  = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_data;

    t_event    event_q[$];
    t_out_item result_q[$];

    int send_idx       = 0;
    int burst_left     = 0;
    int gap_left       = 0;
    int accepted_items = 0;
    int result_count   = 0;
    int mismatch_count = 0;
    int idle_cycles    = 0;
    int stall_cycle    = 0;
    int stall_mode     = 0;

    logic [7:0]  fifo_bytes [FIFO_DEPTH_DEF];
    int          fifo_count  = 0;
    int          tick_count  = 0;
    logic        phase_bit   = 1'b0;
    logic [7:0]  held_byte   = '0;
    t_div        divider     = DIV_1;
    logic        trig3_level = 1'b0;
    logic        dec_reset   = 1'b0;

    int strobes_seen  = 0;
    int full_pushes   = 0;
    int empty_pops    = 0;
    int counter_wraps = 0;

    t_dir_row dir_table [11] = '{
        '{REQ_TICK, 8'h00, 8'd1,  1'b1, '{1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 5'd0}},
        '{REQ_CTRL, 8'h70, 8'd1,  1'b1, '{1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 5'd0}},
        '{REQ_CTRL, 8'h30, 8'd1,  1'b1, '{1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 5'd0}},
        '{REQ_CTRL, 8'h10, 8'd1,  1'b1, '{1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 5'd0}},
        '{REQ_CTRL, 8'h00, 8'd1,  1'b1, '{1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 5'd0}},
        '{REQ_TICK, 8'hFF, 8'd5,  1'b0, '0},
        '{REQ_PUSH, 8'h5A, 8'd17, 1'b0, '0},
        '{REQ_CTC,  8'h00, 8'd1,  1'b1, '{1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 5'd16}},
        '{REQ_CTC,  8'h01, 8'd1,  1'b1, '{1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 5'd16}},
        '{REQ_CTRL, 8'h41, 8'd1,  1'b1, '{1'b0, 1'b0, 1'b0, 8'h00, 1'b1, 5'd0}},
        '{REQ_CTRL, 8'h8E, 8'd1,  1'b0, '0}
    };

    adpcm_sample_fifo_timing dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial begin
        foreach (fifo_bytes[i]) fifo_bytes[i] = '0;
    end

    function automatic t_out_item decode_timing_step(t_in_item it);
        t_out_item pred;
        int        i;
        pred = '0;
        case (it.req_type)
            REQ_TICK: begin
                pred.trigger_two_pulse = ((tick_count & (int'(divider) - 1)) == 0);
                phase_bit = tick_count[PHASE_BIT];
                trig3_level = (fifo_count > 0) || phase_bit;
                if (tick_count == POP_COUNT) begin
                    if (fifo_count > 0) fifo_count--;
                    else empty_pops++;
                    held_byte = fifo_bytes[fifo_count];
                end
                if (fifo_count > 0 && tick_count == STROBE_COUNT) begin
                    pred.sample_strobe = 1'b1;
                    pred.sample_byte   = held_byte;
                    strobes_seen++;
                end
                tick_count = (tick_count + 1) % COUNTER_PERIOD_DEF;
                if (tick_count == 0) counter_wraps++;
            end
            REQ_PUSH: begin
                if (fifo_count < FIFO_DEPTH_DEF) fifo_count++;
                else full_pushes++;
                for (i = fifo_count - 1; i > 0; i--) fifo_bytes[i] = fifo_bytes[i - 1];
                fifo_bytes[0] = it.data_byte;
                trig3_level = 1'b1;
            end
            REQ_CTC: begin
                if (it.data_byte != 8'h00) begin
                    tick_count  = 0;
                    phase_bit   = 1'b0;
                    trig3_level = (fifo_count > 0);
                end
            end
            default: begin
                dec_reset = it.data_byte[CTL_RESET_BIT];
                if (dec_reset) begin
                    fifo_count  = 0;
                    trig3_level = phase_bit;
                end
                if (it.data_byte[CTL_DIV4_BIT]) divider = DIV_4;
                if (it.data_byte[CTL_DIV2_BIT]) divider = DIV_2;
                if (it.data_byte[CTL_DIV1_BIT]) divider = DIV_1;
            end
        endcase
        pred.trigger_three_level = trig3_level;
        pred.decoder_reset       = dec_reset;
        pred.fifo_fill           = FILL_W'(fifo_count);
        return pred;
    endfunction

    task automatic queue_item(t_req req, logic [7:0] data);
        t_event ev;
        ev = '0;
        ev.item.req_type  = req;
        ev.item.data_byte = data;
        event_q.push_back(ev);
    endtask

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("MISMATCH at result %0d: %s got 0x%0h want 0x%0h",
                     result_count, what, got, want);
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want) report_mismatch(name, got, want);
    endtask

    // sender: bursts of random length separated by random gaps
    always @(posedge clk) begin
        if (rst_n && !(in_valid && in_stall)) begin
            if (in_valid) send_idx++;
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (send_idx < event_q.size()) begin
                in_valid <= 1'b1;
                in_data  <= event_q[send_idx].item;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern switches between four randomly drawn modes
    always @(posedge clk) begin
        stall_cycle++;
        if (stall_cycle % 200 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: out_stall <= hold_off;
            1: out_stall <= hold_off | ($urandom_range(0, 99) < 30);
            2: out_stall <= hold_off | (stall_cycle % 5 < 2);
            default: out_stall <= hold_off | ($urandom_range(0, 99) < 70);
        endcase
    end

    // hold off the output long enough to back up the input side
    initial begin
        wait (accepted_items >= HOLD_AFTER);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && in_valid && !in_stall) begin
            want = decode_timing_step(in_data);
            if (event_q[accepted_items].typed) want = event_q[accepted_items].want;
            result_q.push_back(want);
            accepted_items++;
        end
        if (rst_n && out_valid && !out_stall) begin
            if (result_q.size() == 0) begin
                report_mismatch("result with nothing expected", 8'h00, 8'h00);
            end else begin
                want = result_q.pop_front();
                check_field("trigger_two_pulse", 8'(out_data.trigger_two_pulse),
                            8'(want.trigger_two_pulse));
                check_field("trigger_three_level", 8'(out_data.trigger_three_level),
                            8'(want.trigger_three_level));
                check_field("sample_strobe", 8'(out_data.sample_strobe),
                            8'(want.sample_strobe));
                check_field("sample_byte", out_data.sample_byte, want.sample_byte);
                check_field("decoder_reset", 8'(out_data.decoder_reset),
                            8'(want.decoder_reset));
                check_field("fifo_fill", 8'(out_data.fifo_fill), 8'(want.fifo_fill));
            end
            result_count++;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles, %0d of %0d items sent",
                     WATCHDOG_LIMIT, accepted_items, event_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        t_event ev;
        int     seq;
        int     pick;
        seq = 0;
        foreach (dir_table[r]) begin
            for (int k = 0; k < dir_table[r].reps; k++) begin
                ev.item.req_type  = dir_table[r].req;
                ev.item.data_byte = dir_table[r].data + 8'(k);
                ev.typed          = dir_table[r].typed;
                ev.want           = dir_table[r].want;
                event_q.push_back(ev);
            end
        end
        while (event_q.size() < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (seq == 0) begin
                queue_item(REQ_CTC, 8'($urandom_range(1, 255)));
                repeat (3) queue_item(REQ_PUSH, 8'($urandom));
                repeat (COUNTER_PERIOD_DEF + 20) queue_item(REQ_TICK, 8'($urandom));
            end else if (pick < 55) begin
                if ($urandom_range(0, 3) == 0) queue_item(REQ_CTRL, 8'($urandom) & 8'hFE);
                if ($urandom_range(0, 4) != 0) queue_item(REQ_CTC, 8'($urandom_range(1, 255)));
                repeat ($urandom_range(0, 20)) queue_item(REQ_PUSH, 8'($urandom));
                repeat ($urandom_range(70, 80)) begin
                    if ($urandom_range(0, 9) == 0) queue_item(REQ_PUSH, 8'($urandom));
                    else queue_item(REQ_TICK, 8'($urandom));
                end
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 8)) queue_item(t_req'($urandom_range(0, 3)), 8'($urandom));
            end else begin
                queue_item(REQ_CTRL, 8'($urandom));
                repeat ($urandom_range(1, 20)) queue_item(REQ_TICK, 8'($urandom));
            end
            seq++;
        end
        wait (accepted_items == event_q.size());
        wait (result_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Run: %0d transfers in, %0d results checked, %0d mismatched fields",
                 accepted_items, result_count, mismatch_count);
        $display("Covered %0d strobes, %0d full pushes, %0d empty pops, %0d counter wraps",
                 strobes_seen, full_pushes, empty_pops, counter_wraps);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== adpcm_sample_fifo_timing.f =====
hdl/asft_pkg.sv
hdl/asft_mem.sv
hdl/asft_ctrl.sv
hdl/adpcm_sample_fifo_timing.sv
tb/tb_adpcm_sample_fifo_timing.sv
